>>> hw/rtl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg - shared types and constants of the multipart boundary deframer
// register map, character codes, event and status codes, result layout
// ----------------------------------------------------------------------------
package mbd_pkg;

	localparam int BND_BYTES = 32;   // boundary bytes held by the register file
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;
	localparam int LEN_W     = 6;
	localparam int CNT_W     = 48;
	localparam int HDR_W     = 17;

	localparam logic [HDR_W-1:0] HDR_ABS_MAX = 17'h10000;

	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;

	// register index, taken from paddr[5:3]
	typedef enum logic [2:0] {
		REG_BLEN      = 3'd0,
		REG_BND_LO    = 3'd1,
		REG_BND_MID   = 3'd2,
		REG_BND_HI    = 3'd3,
		REG_BND_TOP   = 3'd4,
		REG_BODY_LIM  = 3'd5,
		REG_HDR_LIMIT = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_HDR_END   = 2'd1,
		EV_PART_END  = 2'd2,
		EV_BODY_DONE = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		ST_RUN      = 2'd0,
		ST_DONE     = 2'd1,
		ST_HDR_OVF  = 2'd2,
		ST_SIZE_OVF = 2'd3
	} status_t;

	typedef enum logic [8:0] {
		M_PRE   = 9'b000000001,
		M_AFTER = 9'b000000010,
		M_DASH  = 9'b000000100,
		M_CR    = 9'b000001000,
		M_HDR   = 9'b000010000,
		M_DATA  = 9'b000100000,
		M_DONE  = 9'b001000000,
		M_HERR  = 9'b010000000,
		M_SERR  = 9'b100000000
	} mode_t;

	typedef logic [BND_BYTES-1:0][7:0] bnd_t;

	typedef struct packed {
		logic [LEN_W-1:0] blen;
		bnd_t             bnd;
		logic [CNT_W-1:0] body_lim;
		logic [HDR_W-1:0] hdr_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       byte_kind;
		logic [1:0] event_res;
		logic [1:0] status;
	} res_t;

	// boundary byte, zero beyond the register file
	function automatic logic [7:0] bound_byte(bnd_t bnd, logic [6:0] idx);
		return (idx < 7'(BND_BYTES)) ? bnd[idx[4:0]] : 8'h00;
	endfunction

endpackage

>>> hw/rtl/mbd_cell.sv
// ----------------------------------------------------------------------------
// mbd_cell - one byte cell of the match window
// holds one byte, takes its neighbor's byte on each transfer, compares the
// incoming byte with its expected pattern byte
// ----------------------------------------------------------------------------
module mbd_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] d_in,
	input  logic [7:0] exp_byte,
	output logic [7:0] q,
	output logic       eq
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d_in;
		end
	end

	assign q  = byte_q;
	assign eq = (d_in == exp_byte);

endmodule

>>> hw/rtl/mbd_apb_regs.sv
// ----------------------------------------------------------------------------
// mbd_apb_regs - configuration register file
// registers in 64-bit slots at 8-byte spacing, written on the apb access phase
// ----------------------------------------------------------------------------
module mbd_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mbd_pkg::ADDR_W-1:0] paddr,
	input  logic [mbd_pkg::DATA_W-1:0] pwdata,
	output logic [mbd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output mbd_pkg::cfg_t              cfg,
	output logic                       len_wr
);

	logic [mbd_pkg::LEN_W-1:0]  blen_q;
	logic [mbd_pkg::DATA_W-1:0] bnd_lo_q;
	logic [mbd_pkg::DATA_W-1:0] bnd_mid_q;
	logic [mbd_pkg::DATA_W-1:0] bnd_hi_q;
	logic [mbd_pkg::DATA_W-1:0] bnd_top_q;
	logic [mbd_pkg::CNT_W-1:0]  body_lim_q;
	logic [mbd_pkg::HDR_W-1:0]  hdr_limit_q;
	logic                       wr_en;
	logic [2:0]                 idx;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr_en  = psel & penable & pwrite;
	assign len_wr = wr_en && (idx == mbd_pkg::REG_BLEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q      <= 6'd1;
			bnd_lo_q    <= '0;
			bnd_mid_q   <= '0;
			bnd_hi_q    <= '0;
			bnd_top_q   <= '0;
			body_lim_q  <= '0;
			hdr_limit_q <= mbd_pkg::HDR_ABS_MAX;
		end else if (wr_en) begin
			case (idx)
				mbd_pkg::REG_BLEN:      blen_q      <= pwdata[mbd_pkg::LEN_W-1:0];
				mbd_pkg::REG_BND_LO:    bnd_lo_q    <= pwdata;
				mbd_pkg::REG_BND_MID:   bnd_mid_q   <= pwdata;
				mbd_pkg::REG_BND_HI:    bnd_hi_q    <= pwdata;
				mbd_pkg::REG_BND_TOP:   bnd_top_q   <= pwdata;
				mbd_pkg::REG_BODY_LIM:  body_lim_q  <= pwdata[mbd_pkg::CNT_W-1:0];
				mbd_pkg::REG_HDR_LIMIT: hdr_limit_q <= pwdata[mbd_pkg::HDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mbd_pkg::REG_BLEN:      prdata = 64'(blen_q);
			mbd_pkg::REG_BND_LO:    prdata = bnd_lo_q;
			mbd_pkg::REG_BND_MID:   prdata = bnd_mid_q;
			mbd_pkg::REG_BND_HI:    prdata = bnd_hi_q;
			mbd_pkg::REG_BND_TOP:   prdata = bnd_top_q;
			mbd_pkg::REG_BODY_LIM:  prdata = 64'(body_lim_q);
			mbd_pkg::REG_HDR_LIMIT: prdata = 64'(hdr_limit_q);
			default:                prdata = '0;
		endcase
	end

	assign cfg.blen      = blen_q;
	assign cfg.bnd       = {bnd_top_q, bnd_hi_q, bnd_mid_q, bnd_lo_q};
	assign cfg.body_lim  = body_lim_q;
	assign cfg.hdr_limit = hdr_limit_q;

endmodule

>>> hw/rtl/mbd_out_skid.sv
// ----------------------------------------------------------------------------
// mbd_out_skid - output register with one skid entry
// keeps input ready registered so a stalled sink does not reach the parser
// ----------------------------------------------------------------------------
module mbd_out_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  mbd_pkg::res_t up_data,
	output logic          dn_valid,
	input  logic          dn_ready,
	output mbd_pkg::res_t dn_data
);

	logic          main_v_q;
	logic          skid_v_q;
	mbd_pkg::res_t main_q;
	mbd_pkg::res_t skid_q;
	logic          up_fire;
	logic          main_free;

	assign up_ready  = !skid_v_q;
	assign up_fire   = up_valid && !skid_v_q;
	assign main_free = !main_v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= up_fire;
			end
		end else if (up_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (up_fire) begin
				main_q <= up_data;
			end
		end else if (up_fire) begin
			skid_q <= up_data;
		end
	end

	assign dn_valid = main_v_q;
	assign dn_data  = main_q;

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry held while output register empty");

endmodule

>>> hw/rtl/multipart_boundary_deframer.sv
// ----------------------------------------------------------------------------
// multipart_boundary_deframer - byte-serial multipart body deframer
// Takes one body byte per transfer and returns one result per byte: a released
// header or data byte, a header-end / part-end / body-done event, and the
// parse status. It sustains one transfer per clock while the sink keeps up.
// Each result is registered in the output register; a stalled sink parks one
// result in a skid entry and then drops in_ready. The match window, a row of
// MAX_BOUNDARY_BYTES+4 byte cells that shift on every transfer and are compared
// against the boundary pattern in parallel, does all of a byte's parse work
// combinationally ahead of the output register. There is no clearing pass
// after reset. Configuration goes through the apb port at 8-byte register
// spacing; the user must write it only while the block holds no pending work,
// which the block does not enforce. A boundary length write empties the window.
// ----------------------------------------------------------------------------
module multipart_boundary_deframer #(
	parameter int MAX_BOUNDARY_BYTES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// apb configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mbd_pkg::ADDR_W-1:0] paddr,
	input  logic [mbd_pkg::DATA_W-1:0] pwdata,
	output logic [mbd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	// byte input
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       body_start,
	// result output
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       byte_valid,
	output logic                       byte_kind,
	output logic [1:0]                 event_res,
	output logic [1:0]                 status
);

	// window depth: CR LF dash dash plus the boundary string
	localparam int WIN = MAX_BOUNDARY_BYTES + 4;
	localparam int XW  = $clog2(WIN + 1);
	localparam int IW  = $clog2(WIN);

	mbd_pkg::cfg_t cfg;
	logic          len_wr;

	mbd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.len_wr  (len_wr)
	);

	// parse state
	mbd_pkg::mode_t            mode_q;
	logic [XW-1:0]             fill_q;
	logic [mbd_pkg::CNT_W-1:0] seen_q;
	logic [mbd_pkg::HDR_W-1:0] hcnt_q;

	logic in_fire;
	logic res_ready;

	assign in_ready = res_ready;
	assign in_fire  = in_valid && res_ready;

	// effective lengths from the configuration
	logic [XW-1:0]             len_x;
	logic [XW-1:0]             pl;
	logic [XW-1:0]             pl2;
	logic [mbd_pkg::HDR_W-1:0] hlim_eff;

	always_comb begin
		if (cfg.blen == '0) begin
			len_x = XW'(1);
		end else if ({1'b0, cfg.blen} > 7'(MAX_BOUNDARY_BYTES)) begin
			len_x = XW'(MAX_BOUNDARY_BYTES);
		end else begin
			len_x = XW'(cfg.blen);
		end
	end

	// "--" boundary and CR LF "--" boundary lengths
	assign pl  = len_x + XW'(2);
	assign pl2 = len_x + XW'(4);

	always_comb begin
		if (cfg.hdr_limit == '0) begin
			hlim_eff = mbd_pkg::HDR_W'(1);
		end else if (cfg.hdr_limit > mbd_pkg::HDR_ABS_MAX) begin
			hlim_eff = mbd_pkg::HDR_ABS_MAX;
		end else begin
			hlim_eff = cfg.hdr_limit;
		end
	end

	// the window as a chain of cells: cell 0 takes the new byte, cell k holds
	// the byte k places back; the oldest live byte sits at cell fill-1
	logic       dash_load;
	logic [7:0] nxt_byte [WIN];
	logic [7:0] cell_q   [WIN];
	logic [WIN-1:0] eq;
	logic [WIN-1:0] mask0;
	logic [WIN-1:0] mask1;

	// a dash after a boundary followed by another byte: both enter the header
	assign dash_load = !body_start && (mode_q == mbd_pkg::M_DASH);

	for (genvar k = 0; k < WIN; k++) begin : g_win
		logic [7:0] exp_k;

		if (k == 0) begin : g_head
			assign nxt_byte[k] = data_byte;
		end else if (k == 1) begin : g_second
			assign nxt_byte[k] = dash_load ? mbd_pkg::CH_DASH : cell_q[0];
		end else begin : g_tail
			assign nxt_byte[k] = cell_q[k-1];
		end

		// pattern read newest first: boundary reversed, two dashes, LF, CR
		always_comb begin
			exp_k = mbd_pkg::CH_CR;
			if (XW'(k) < len_x) begin
				exp_k = mbd_pkg::bound_byte(cfg.bnd, 7'(len_x - XW'(k) - XW'(1)));
			end else if (XW'(k) < pl) begin
				exp_k = mbd_pkg::CH_DASH;
			end else if (XW'(k) == pl) begin
				exp_k = mbd_pkg::CH_LF;
			end
		end

		assign mask0[k] = (XW'(k) < pl);
		assign mask1[k] = (XW'(k) < pl2);

		mbd_cell u_cell (
			.clk      (clk),
			.shift    (in_fire),
			.d_in     (nxt_byte[k]),
			.exp_byte (exp_k),
			.q        (cell_q[k]),
			.eq       (eq[k])
		);
	end

	logic       hdr_end_seen;
	logic [7:0] data_tap;

	assign hdr_end_seen = (nxt_byte[0] == mbd_pkg::CH_LF) && (nxt_byte[1] == mbd_pkg::CH_CR)
		&& (nxt_byte[2] == mbd_pkg::CH_LF) && (nxt_byte[3] == mbd_pkg::CH_CR);

	// oldest byte of a full data window
	assign data_tap = nxt_byte[IW'(len_x + XW'(3))];

	// per-byte parse step
	mbd_pkg::mode_t            mode;
	mbd_pkg::mode_t            cur;
	mbd_pkg::mode_t            mode_n;
	logic [XW-1:0]             fill;
	logic [XW-1:0]             fill_push;
	logic [XW-1:0]             fill_n;
	logic [mbd_pkg::CNT_W-1:0] seen;
	logic [mbd_pkg::CNT_W-1:0] seen_n;
	logic [mbd_pkg::HDR_W-1:0] hcnt;
	logic [mbd_pkg::HDR_W-1:0] hcnt_n;
	logic                      running;
	logic                      bnd_match;
	logic                      delim_match;
	mbd_pkg::res_t             res;

	// body_start restarts the parse ahead of this byte
	assign mode      = body_start ? mbd_pkg::M_PRE : mode_q;
	assign fill      = body_start ? '0 : fill_q;
	assign seen      = body_start ? '0 : seen_q;
	assign hcnt      = body_start ? '0 : hcnt_q;
	assign fill_push = fill + XW'(1);
	assign running   = !((mode == mbd_pkg::M_DONE) || (mode == mbd_pkg::M_HERR)
		|| (mode == mbd_pkg::M_SERR));

	assign bnd_match   = (fill_push == pl) && (&(eq | ~mask0));
	assign delim_match = (fill_push == pl2) && (&(eq | ~mask1));

	always_comb begin
		cur    = mode;
		seen_n = seen;
		hcnt_n = hcnt;
		fill_n = fill;
		res    = '0;

		// size limit counts every byte taken while running
		if (running) begin
			if (seen != '1) begin
				seen_n = seen + mbd_pkg::CNT_W'(1);
			end
			if ((cfg.body_lim != '0) && (seen_n > cfg.body_lim)) begin
				cur = mbd_pkg::M_SERR;
			end
		end
		mode_n = cur;

		case (cur)
			mbd_pkg::M_PRE: begin
				if (bnd_match) begin
					mode_n = mbd_pkg::M_AFTER;
					fill_n = '0;
				end else if (fill_push >= pl) begin
					fill_n = fill;
				end else begin
					fill_n = fill_push;
				end
			end
			mbd_pkg::M_AFTER: begin
				hcnt_n = '0;
				if (data_byte == mbd_pkg::CH_DASH) begin
					mode_n = mbd_pkg::M_DASH;
				end else if (data_byte == mbd_pkg::CH_CR) begin
					mode_n = mbd_pkg::M_CR;
				end else if (data_byte == mbd_pkg::CH_LF) begin
					mode_n = mbd_pkg::M_HDR;
					fill_n = '0;
				end else begin
					mode_n = mbd_pkg::M_HDR;
					fill_n = XW'(1);
				end
			end
			mbd_pkg::M_DASH: begin
				if (data_byte == mbd_pkg::CH_DASH) begin
					mode_n        = mbd_pkg::M_DONE;
					res.event_res = mbd_pkg::EV_BODY_DONE;
				end else begin
					// dash and this byte open the header
					mode_n = mbd_pkg::M_HDR;
					hcnt_n = '0;
					fill_n = XW'(2);
				end
			end
			mbd_pkg::M_CR: begin
				mode_n = mbd_pkg::M_HDR;
				hcnt_n = '0;
				fill_n = (data_byte == mbd_pkg::CH_LF) ? '0 : XW'(1);
			end
			mbd_pkg::M_HDR: begin
				if ((fill_push == XW'(4)) && hdr_end_seen) begin
					mode_n        = mbd_pkg::M_DATA;
					fill_n        = '0;
					res.event_res = mbd_pkg::EV_HDR_END;
				end else if (fill_push >= XW'(4)) begin
					if (hcnt >= hlim_eff) begin
						mode_n = mbd_pkg::M_HERR;
					end else begin
						res.out_byte   = nxt_byte[3];
						res.byte_valid = 1'b1;
						hcnt_n         = hcnt + mbd_pkg::HDR_W'(1);
						fill_n         = fill;
					end
				end else begin
					fill_n = fill_push;
				end
			end
			mbd_pkg::M_DATA: begin
				if (delim_match) begin
					mode_n        = mbd_pkg::M_AFTER;
					fill_n        = '0;
					res.event_res = mbd_pkg::EV_PART_END;
				end else if (fill_push >= pl2) begin
					res.out_byte   = data_tap;
					res.byte_valid = 1'b1;
					res.byte_kind  = 1'b1;
					fill_n         = fill;
				end else begin
					fill_n = fill_push;
				end
			end
			default: ;
		endcase

		case (mode_n)
			mbd_pkg::M_DONE: res.status = mbd_pkg::ST_DONE;
			mbd_pkg::M_HERR: res.status = mbd_pkg::ST_HDR_OVF;
			mbd_pkg::M_SERR: res.status = mbd_pkg::ST_SIZE_OVF;
			default:         res.status = mbd_pkg::ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mbd_pkg::M_PRE;
			fill_q <= '0;
			seen_q <= '0;
			hcnt_q <= '0;
		end else begin
			if (in_fire) begin
				mode_q <= mode_n;
				seen_q <= seen_n;
				hcnt_q <= hcnt_n;
			end
			// a new boundary length empties the window
			if (len_wr) begin
				fill_q <= '0;
			end else if (in_fire) begin
				fill_q <= fill_n;
			end
		end
	end

	// output register and skid entry
	mbd_pkg::res_t out_res;

	mbd_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (res_ready),
		.up_data  (res),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_data  (out_res)
	);

	assign out_byte   = out_res.out_byte;
	assign byte_valid = out_res.byte_valid;
	assign byte_kind  = out_res.byte_kind;
	assign event_res  = out_res.event_res;
	assign status     = out_res.status;

	a_data_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == mbd_pkg::M_DATA) |-> (fill_q < pl2))
		else $error("data window holds a full delimiter length");

	a_hdr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == mbd_pkg::M_HDR) |-> (fill_q < XW'(4)))
		else $error("header window over three bytes");

	a_byte_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_valid) |-> (event_res == mbd_pkg::EV_NONE))
		else $error("released byte carries an event");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((status == mbd_pkg::ST_HDR_OVF) || (status == mbd_pkg::ST_SIZE_OVF)))
		|-> (!byte_valid && (event_res == mbd_pkg::EV_NONE)))
		else $error("error status with byte or event");

endmodule
